// File: sv/bms_pkg.sv
// Shared types and codes for the byte machine step core.
`default_nettype none

package bms_pkg;

   typedef enum logic [1:0] {
      CMD_STEP = 2'd0,
      CMD_LOAD = 2'd1,
      CMD_READ = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OPC_NONE = 2'd0,
      OPC_SET  = 2'd1,
      OPC_COPY = 2'd2,
      OPC_JUMP = 2'd3
   } opcode_type;

   typedef struct packed {
      logic       wr_en;
      logic [7:0] wr_addr;
      logic [7:0] wr_data;
      logic [7:0] rd_addr;
   } mem_req_type;

endpackage

`default_nettype wire

// File: sv/byte_machine_step_core.sv
// Top level of the byte machine step core.
// A step beat is sequenced through the single-read-port byte memory with a registered
// read: the opcode, the two operand bytes and the COPY source are read one after
// another, then the result is registered. A step whose pointer sits in the last two
// bytes skips the fetch, as a load does; a read fetches its one byte. The next beat is
// taken as soon as the result is registered, even while it waits on rsp_stall.
// Memory contents are undefined until loaded.
`default_nettype none

module byte_machine_step_core
   import bms_pkg::*;
#(
   parameter int MEM_BYTES = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_cmd,
   input  wire logic [7:0] req_mem_addr,
   input  wire logic [7:0] req_load_value,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_next_pc,
   output logic [1:0]      rsp_op_done,
   output logic            rsp_did_write,
   output logic [7:0]      rsp_write_addr,
   output logic [7:0]      rsp_write_value,
   output logic [7:0]      rsp_read_value
);

   mem_req_type mem_req;
   logic [7:0]  rd_data;

   bms_ctrl #(
      .MEM_BYTES(MEM_BYTES)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_mem_addr   (req_mem_addr),
      .req_load_value (req_load_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_next_pc    (rsp_next_pc),
      .rsp_op_done    (rsp_op_done),
      .rsp_did_write  (rsp_did_write),
      .rsp_write_addr (rsp_write_addr),
      .rsp_write_value(rsp_write_value),
      .rsp_read_value (rsp_read_value),
      .mem_req        (mem_req),
      .rd_data        (rd_data)
   );

   bms_mem #(
      .MEM_BYTES(MEM_BYTES)
   ) u_mem (
      .clock     (clock),
      .mem_req   (mem_req),
      .rd_data_ff(rd_data)
   );

endmodule

`default_nettype wire

// File: sv/bms_mem.sv
// Byte memory with one write port and one registered read port.
`default_nettype none

module bms_mem
   import bms_pkg::*;
#(
   parameter int MEM_BYTES = 256
) (
   input  wire logic        clock,
   input  wire mem_req_type mem_req,
   output logic [7:0]       rd_data_ff
);

   localparam int AW = $clog2(MEM_BYTES);

   logic [7:0] mem [MEM_BYTES];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
      end
      rd_data_ff <= mem[mem_req.rd_addr[AW-1:0]];
   end

endmodule

`default_nettype wire

// File: sv/bms_ctrl.sv
// Step sequencer: fetches operands, issues writes, holds the pointer and result beat.
`default_nettype none

module bms_ctrl
   import bms_pkg::*;
#(
   parameter int MEM_BYTES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_mem_addr,
   input  wire logic [7:0]  req_load_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_next_pc,
   output logic [1:0]       rsp_op_done,
   output logic             rsp_did_write,
   output logic [7:0]       rsp_write_addr,
   output logic [7:0]       rsp_write_value,
   output logic [7:0]       rsp_read_value,
   output mem_req_type      mem_req,
   input  wire logic [7:0]  rd_data
);

   localparam int AW = $clog2(MEM_BYTES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_FETCH_OP,
      ST_FETCH_B1,
      ST_FETCH_B2,
      ST_COPY_SRC,
      ST_DONE
   } state_type;

   state_type  state_ff;
   logic [AW-1:0] pc_ff;
   opcode_type op_ff;
   logic [7:0] b1_ff;
   logic [7:0] b2_ff;

   opcode_type res_op_ff;
   logic       res_did_ff;
   logic [7:0] res_waddr_ff;
   logic [7:0] res_wval_ff;
   logic [7:0] res_rval_ff;

   logic       rsp_valid_ff;
   logic [7:0] rsp_next_pc_ff;
   logic [1:0] rsp_op_done_ff;
   logic       rsp_did_write_ff;
   logic [7:0] rsp_write_addr_ff;
   logic [7:0] rsp_write_value_ff;
   logic [7:0] rsp_read_value_ff;

   logic [AW-1:0] wrap_tab [256];
   logic [AW-1:0] pc_inc;
   logic [AW-1:0] tgt;
   logic [AW-1:0] tgt_inc;
   logic [7:0]    pc_byte;
   logic          step_ok;
   logic          accept;

   for (genvar i = 0; i < 256; i++) begin : g_wrap
      assign wrap_tab[i] = AW'(i % MEM_BYTES);
   end

   assign pc_byte = 8'(pc_ff);
   assign pc_inc  = (pc_ff == AW'(MEM_BYTES - 1)) ? '0 : pc_ff + AW'(1);
   assign tgt     = wrap_tab[b1_ff];
   assign tgt_inc = (tgt == AW'(MEM_BYTES - 1)) ? '0 : tgt + AW'(1);
   assign step_ok = (9'(pc_ff) + 9'd2) < 9'(MEM_BYTES);
   assign accept  = req_valid && !req_stall;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      mem_req = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_cmd == CMD_STEP) begin
               mem_req.rd_addr = pc_byte;
            end else begin
               mem_req.rd_addr = 8'(wrap_tab[req_mem_addr]);
            end
            if (accept && req_cmd == CMD_LOAD) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = 8'(wrap_tab[req_mem_addr]);
               mem_req.wr_data = req_load_value;
            end
         end
         ST_FETCH_OP: mem_req.rd_addr = pc_byte + 8'd1;
         ST_FETCH_B1: mem_req.rd_addr = pc_byte + 8'd2;
         ST_FETCH_B2: begin
            mem_req.rd_addr = 8'(tgt);
            if (op_ff == OPC_SET) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = 8'(tgt);
               mem_req.wr_data = rd_data;
            end else if (op_ff == OPC_JUMP && rd_data != 8'd0) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pc_byte + 8'd2;
               mem_req.wr_data = rd_data - 8'd1;
            end
         end
         ST_COPY_SRC: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = 8'(wrap_tab[b2_ff]);
            mem_req.wr_data = rd_data;
         end
         default: mem_req = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  res_op_ff    <= OPC_NONE;
                  res_did_ff   <= 1'b0;
                  res_waddr_ff <= 8'd0;
                  res_wval_ff  <= 8'd0;
                  res_rval_ff  <= 8'd0;
                  case (req_cmd)
                     CMD_STEP: begin
                        if (step_ok) begin
                           state_ff <= ST_FETCH_OP;
                        end else begin
                           pc_ff    <= pc_inc;
                           state_ff <= ST_DONE;
                        end
                     end
                     CMD_READ: state_ff <= ST_READ;
                     default:  state_ff <= ST_DONE;
                  endcase
               end
            end
            ST_READ: begin
               res_rval_ff <= rd_data;
               state_ff    <= ST_DONE;
            end
            ST_FETCH_OP: begin
               op_ff    <= opcode_type'(rd_data[1:0]);
               state_ff <= ST_FETCH_B1;
            end
            ST_FETCH_B1: begin
               b1_ff    <= rd_data;
               state_ff <= ST_FETCH_B2;
            end
            ST_FETCH_B2: begin
               b2_ff <= rd_data;
               case (op_ff)
                  OPC_SET: begin
                     res_op_ff    <= OPC_SET;
                     res_did_ff   <= 1'b1;
                     res_waddr_ff <= 8'(tgt);
                     res_wval_ff  <= rd_data;
                     pc_ff        <= pc_inc;
                     state_ff     <= ST_DONE;
                  end
                  OPC_COPY: state_ff <= ST_COPY_SRC;
                  OPC_JUMP: begin
                     res_op_ff <= OPC_JUMP;
                     if (rd_data != 8'd0) begin
                        res_did_ff   <= 1'b1;
                        res_waddr_ff <= pc_byte + 8'd2;
                        res_wval_ff  <= rd_data - 8'd1;
                        pc_ff        <= tgt_inc;
                     end else begin
                        pc_ff <= pc_inc;
                     end
                     state_ff <= ST_DONE;
                  end
                  default: begin
                     pc_ff    <= pc_inc;
                     state_ff <= ST_DONE;
                  end
               endcase
            end
            ST_COPY_SRC: begin
               res_op_ff    <= OPC_COPY;
               res_did_ff   <= 1'b1;
               res_waddr_ff <= 8'(wrap_tab[b2_ff]);
               res_wval_ff  <= rd_data;
               pc_ff        <= pc_inc;
               state_ff     <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_next_pc_ff     <= pc_byte;
                  rsp_op_done_ff     <= res_op_ff;
                  rsp_did_write_ff   <= res_did_ff;
                  rsp_write_addr_ff  <= res_waddr_ff;
                  rsp_write_value_ff <= res_wval_ff;
                  rsp_read_value_ff  <= res_rval_ff;
                  state_ff           <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_pc     = rsp_next_pc_ff;
   assign rsp_op_done     = rsp_op_done_ff;
   assign rsp_did_write   = rsp_did_write_ff;
   assign rsp_write_addr  = rsp_write_addr_ff;
   assign rsp_write_value = rsp_write_value_ff;
   assign rsp_read_value  = rsp_read_value_ff;

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      (9'(pc_ff) < 9'(MEM_BYTES)))
      else $error("program pointer beyond memory");

   a_wr_state: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> (state_ff == ST_IDLE || state_ff == ST_FETCH_B2 ||
                         state_ff == ST_COPY_SRC))
      else $error("memory write outside a write phase");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result beat raised outside done phase");

   a_step_fetch: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_STEP && step_ok) |=> (state_ff == ST_FETCH_OP))
      else $error("step did not start its fetch");

endmodule

`default_nettype wire

// File: tb/byte_machine_step_core_tb.sv
// Self-checking testbench for the byte machine step core: directed table, then random programs.
module byte_machine_step_core_tb
   import bms_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD = 10;
   localparam int MACHINE_BYTES = 256;
   localparam int DIRECTED_ROWS = 24;
   localparam int RANDOM_BEATS = 1900;
   localparam int HOLD_CYCLES = 80;
   localparam int LIMIT_NS = 8_000_000;

   typedef struct packed {
      logic [7:0] next_pc;
      opcode_type op;
      logic       did_write;
      logic [7:0] waddr;
      logic [7:0] wval;
      logic [7:0] rval;
   } rsp_beat_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] addr;
      logic [7:0] val;
      logic       typed;
      logic [7:0] exp_pc;
      logic [7:0] exp_rval;
   } stim_row_type;

   typedef enum int {
      STALL_NONE,
      STALL_HALF,
      STALL_LIGHT,
      STALL_HEAVY
   } stall_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_cmd = 2'd0;
   logic [7:0] req_mem_addr = 8'd0;
   logic [7:0] req_load_value = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_next_pc;
   logic [1:0] rsp_op_done;
   logic       rsp_did_write;
   logic [7:0] rsp_write_addr;
   logic [7:0] rsp_write_value;
   logic [7:0] rsp_read_value;

   logic [7:0] mem_img [MACHINE_BYTES];
   bit         written [MACHINE_BYTES];
   logic [7:0] pc_img = 8'd0;

   rsp_beat_type machine_results_q [$];
   int         mismatches = 0;
   int         real_beats = 0;
   int         burst_left = 0;
   logic       hold_off_req = 1'b0;

   byte_machine_step_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_mem_addr    (req_mem_addr),
      .req_load_value  (req_load_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_next_pc     (rsp_next_pc),
      .rsp_op_done     (rsp_op_done),
      .rsp_did_write   (rsp_did_write),
      .rsp_write_addr  (rsp_write_addr),
      .rsp_write_value (rsp_write_value),
      .rsp_read_value  (rsp_read_value)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic rsp_beat_type advance_machine(cmd_type cmd, logic [7:0] addr,
                                                    logic [7:0] val);
      rsp_beat_type r;
      opcode_type opc;
      logic [7:0] b1;
      logic [7:0] b2;
      r = '0;
      case (cmd)
         CMD_LOAD: begin
            mem_img[addr] = val;
            written[addr] = 1'b1;
         end
         CMD_READ: begin
            r.rval = mem_img[addr];
         end
         CMD_STEP: begin
            if (int'(pc_img) + 2 < MACHINE_BYTES) begin
               opc = opcode_type'(mem_img[pc_img][1:0]);
               b1 = mem_img[pc_img + 8'd1];
               b2 = mem_img[pc_img + 8'd2];
               case (opc)
                  OPC_SET: begin
                     r.op = OPC_SET;
                     r.did_write = 1'b1;
                     r.waddr = b1;
                     r.wval = b2;
                  end
                  OPC_COPY: begin
                     r.op = OPC_COPY;
                     r.did_write = 1'b1;
                     r.waddr = b2;
                     r.wval = mem_img[b1];
                  end
                  OPC_JUMP: begin
                     r.op = OPC_JUMP;
                     if (b2 != 8'd0) begin
                        r.did_write = 1'b1;
                        r.waddr = pc_img + 8'd2;
                        r.wval = b2 - 8'd1;
                        pc_img = b1;
                     end
                  end
                  default: ;
               endcase
               if (r.did_write) begin
                  mem_img[r.waddr] = r.wval;
                  written[r.waddr] = 1'b1;
               end
            end
            pc_img = pc_img + 8'd1;
         end
         default: ;
      endcase
      r.next_pc = pc_img;
      return r;
   endfunction

   function automatic stim_row_type mk_row(cmd_type cmd, logic [7:0] addr, logic [7:0] val,
                                           logic typed, logic [7:0] exp_pc,
                                           logic [7:0] exp_rval);
      stim_row_type s;
      s.cmd = cmd;
      s.addr = addr;
      s.val = val;
      s.typed = typed;
      s.exp_pc = exp_pc;
      s.exp_rval = exp_rval;
      return s;
   endfunction

   task automatic drive_beat(cmd_type cmd, logic [7:0] addr, logic [7:0] val, bit typed,
                             rsp_beat_type typed_rsp);
      int           gap;
      rsp_beat_type pred;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_mem_addr <= addr;
      req_load_value <= val;
      do @(posedge clock); while (req_stall);
      pred = advance_machine(cmd, addr, val);
      machine_results_q.push_back(typed ? typed_rsp : pred);
      if (cmd != CMD_NONE)
         real_beats++;
   endtask

   task automatic preload_byte(logic [7:0] addr);
      if (!written[addr])
         drive_beat(CMD_LOAD, addr, 8'($urandom_range(0, 255)), 1'b0, '0);
   endtask

   // fill every byte the beat will read before sending it
   task automatic issue_beat(cmd_type cmd, logic [7:0] addr, logic [7:0] val);
      if (cmd == CMD_READ)
         preload_byte(addr);
      if (cmd == CMD_STEP && int'(pc_img) + 2 < MACHINE_BYTES) begin
         preload_byte(pc_img);
         preload_byte(pc_img + 8'd1);
         preload_byte(pc_img + 8'd2);
         if (mem_img[pc_img][1:0] == OPC_COPY)
            preload_byte(mem_img[pc_img + 8'd1]);
      end
      drive_beat(cmd, addr, val, 1'b0, '0);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (machine_results_q.size() != 0);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      stim_row_type directed_rows [DIRECTED_ROWS];
      rsp_beat_type typed_rsp;
      logic [7:0]  base;
      logic [7:0]  target;
      int          sel;
      bit          hold_done;
      bit          pause_done;
      hold_done = 1'b0;
      pause_done = 1'b0;
      directed_rows[0]  = mk_row(CMD_LOAD, 8'h00, 8'h01, 1'b1, 8'h00, 8'h00);
      directed_rows[1]  = mk_row(CMD_LOAD, 8'h01, 8'hFF, 1'b1, 8'h00, 8'h00);
      directed_rows[2]  = mk_row(CMD_LOAD, 8'h02, 8'h00, 1'b1, 8'h00, 8'h00);
      directed_rows[3]  = mk_row(CMD_NONE, 8'hFF, 8'hFF, 1'b1, 8'h00, 8'h00);
      directed_rows[4]  = mk_row(CMD_READ, 8'h01, 8'h00, 1'b1, 8'h00, 8'hFF);
      directed_rows[5]  = mk_row(CMD_STEP, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00);
      directed_rows[6]  = mk_row(CMD_LOAD, 8'h03, 8'h02, 1'b0, 8'h00, 8'h00);
      directed_rows[7]  = mk_row(CMD_STEP, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
      directed_rows[8]  = mk_row(CMD_STEP, 8'h55, 8'hAA, 1'b0, 8'h00, 8'h00);
      directed_rows[9]  = mk_row(CMD_STEP, 8'hAA, 8'h55, 1'b0, 8'h00, 8'h00);
      directed_rows[10] = mk_row(CMD_LOAD, 8'h04, 8'hFF, 1'b0, 8'h00, 8'h00);
      directed_rows[11] = mk_row(CMD_STEP, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
      directed_rows[12] = mk_row(CMD_LOAD, 8'h03, 8'h02, 1'b0, 8'h00, 8'h00);
      directed_rows[13] = mk_row(CMD_LOAD, 8'h05, 8'hFD, 1'b0, 8'h00, 8'h00);
      directed_rows[14] = mk_row(CMD_STEP, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
      directed_rows[15] = mk_row(CMD_LOAD, 8'h06, 8'h01, 1'b0, 8'h00, 8'h00);
      directed_rows[16] = mk_row(CMD_STEP, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
      directed_rows[17] = mk_row(CMD_STEP, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
      directed_rows[18] = mk_row(CMD_STEP, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
      directed_rows[19] = mk_row(CMD_LOAD, 8'hFF, 8'h55, 1'b1, 8'h00, 8'h00);
      directed_rows[20] = mk_row(CMD_READ, 8'hFF, 8'h00, 1'b1, 8'h00, 8'h55);
      directed_rows[21] = mk_row(CMD_READ, 8'hFD, 8'hFF, 1'b0, 8'h00, 8'h00);
      directed_rows[22] = mk_row(CMD_NONE, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00);
      directed_rows[23] = mk_row(CMD_STEP, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);

      do @(posedge clock); while (reset);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].typed) begin
            typed_rsp = '0;
            typed_rsp.next_pc = directed_rows[i].exp_pc;
            typed_rsp.rval = directed_rows[i].exp_rval;
            drive_beat(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].val,
                       1'b1, typed_rsp);
         end else begin
            issue_beat(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].val);
         end
      end

      while (real_beats < DIRECTED_ROWS + RANDOM_BEATS) begin
         if (!hold_done && real_beats > 400) begin
            hold_off_req <= 1'b1;
            hold_done = 1'b1;
         end
         if (!pause_done && real_beats > 1000) begin
            drain_results();
            pause_done = 1'b1;
         end
         sel = $urandom_range(0, 99);
         if (sel < 55) begin
            issue_beat(CMD_STEP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else if (sel < 65) begin
            // plant a short program at the pointer
            base = pc_img;
            if (int'(base) + 2 < MACHINE_BYTES) begin
               case ($urandom_range(0, 3))
                  0: target = 8'hFD;
                  1: target = base - 8'd1;
                  default: target = 8'($urandom_range(0, 255));
               endcase
               drive_beat(CMD_LOAD, base, 8'($urandom_range(0, 255)), 1'b0, '0);
               drive_beat(CMD_LOAD, base + 8'd1, target, 1'b0, '0);
               drive_beat(CMD_LOAD, base + 8'd2,
                          8'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                  : $urandom_range(0, 255)),
                          1'b0, '0);
            end else begin
               issue_beat(CMD_STEP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
         end else if (sel < 78) begin
            issue_beat(CMD_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else if (sel < 95) begin
            issue_beat(CMD_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else begin
            issue_beat(CMD_NONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && machine_results_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      stall_mode_type mode;
      int          mode_left;
      mode = STALL_NONE;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req <= 1'b0;
            rsp_stall <= 1'b1;
            for (int n = 0; n < HOLD_CYCLES; n++)
               @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(10, 150);
            end
            mode_left--;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_HALF:  rsp_stall <= 1'($urandom_range(0, 1));
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               default:     rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_beat_type got;
      rsp_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.next_pc = rsp_next_pc;
         got.op = opcode_type'(rsp_op_done);
         got.did_write = rsp_did_write;
         got.waddr = rsp_write_addr;
         got.wval = rsp_write_value;
         got.rval = rsp_read_value;
         if (machine_results_q.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected beat: pc=%h op=%0d wr=%b wa=%h wv=%h rd=%h",
                        got.next_pc, got.op, got.did_write, got.waddr, got.wval, got.rval);
            mismatches++;
         end else begin
            want = machine_results_q.pop_front();
            if (got.next_pc !== want.next_pc || got.op !== want.op ||
                got.did_write !== want.did_write || got.waddr !== want.waddr ||
                got.wval !== want.wval || got.rval !== want.rval) begin
               if (mismatches < 10)
                  $display("mismatch: exp %h/%0d/%b/%h/%h/%h got %h/%0d/%b/%h/%h/%h",
                           want.next_pc, want.op, want.did_write, want.waddr, want.wval,
                           want.rval, got.next_pc, got.op, got.did_write, got.waddr,
                           got.wval, got.rval);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #(LIMIT_NS);
      $display("Verification failed");
      $finish;
   end

endmodule
